>>> hdl/sdv_pkg.sv
package sdv_pkg;

  // Fixed widths of the item fields
  localparam int DATE_W = 40;
  localparam int OUT_W  = 32;

  // Number formats
  localparam int TIME_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS  = 30;
  localparam int ANGLE_BITS     = 32;

  // Latency of one sine unit: angle scale and square (two stages each),
  // eight four-stage series steps, clamp
  localparam int SIN_LAT  = 37;
  // Date reg, time terms (3), sine, center terms (2), longitude, sine,
  // products (2), rounding
  localparam int PIPE_LAT = 10 + 2 * SIN_LAT;

  localparam logic [63:0] HALF_PI_Q62    = 64'h6487ED5110B4611A;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] ONE_Q62        = 64'h4000000000000000;
  localparam logic [63:0] QUARTER_TURN   = 64'h4000000000000000;
  localparam logic [63:0] ANGLE_MASK     = {64{1'b1}} << (64 - ANGLE_BITS);

  typedef logic [63:0] word_t;

  // Four 32x32 partial products of a 64x64 product
  typedef struct packed {
    word_t p11;
    word_t p10;
    word_t p01;
    word_t p00;
  } pp_t;

  function automatic pp_t mul_pp(input word_t a, input word_t b);
    pp_t p;
    p.p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    p.p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    p.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    p.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    return p;
  endfunction

  // Sum of partial products: the full 128-bit product
  function automatic logic [127:0] pp_sum(input pp_t p);
    return {p.p11, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0};
  endfunction

  // Full 128-bit product, elaboration only
  function automatic logic [127:0] mul_full(input word_t a, input word_t b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  function automatic word_t mul_hi(input word_t a, input word_t b);
    logic [127:0] p;
    p = mul_full(a, b);
    return p[127:64];
  endfunction

  // floor(num * 2^64 / den), elaboration only
  function automatic word_t frac_q64(input word_t num, input word_t den);
    word_t r;
    word_t q;
    r = num;
    q = '0;
    for (int i = 0; i < 64; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // ceil(2^(64+l) / d) with l = clog2(d), elaboration only; bit 64 is always set
  function automatic logic [64:0] recip_m(input int d, input int l);
    logic [79:0] n;
    logic [79:0] q;
    n = (80'd1 << (64 + l)) + 80'(d) - 80'd1;
    q = n / 80'(d);
    return q[64:0];
  endfunction

  // Date times rate per day, fraction bits of the date dropped
  function automatic word_t time_term(input word_t date, input word_t rate);
    logic [127:0] p;
    p = mul_full(date, rate);
    return p[TIME_FRAC_BITS +: 64];
  endfunction

  // Round Q2.62 magnitude to the output format and apply sign
  function automatic logic [OUT_W-1:0] encode_out(input word_t mag, input logic neg);
    word_t r;
    r = (mag + (word_t'(1) << (61 - OUT_FRAC_BITS))) >> (62 - OUT_FRAC_BITS);
    if (neg) begin
      r = word_t'(0) - r;
    end
    return r[OUT_W-1:0];
  endfunction

  // Model constants
  localparam word_t J2000_DATE = word_t'(2451545) << TIME_FRAC_BITS;
  localparam word_t C_G    = frac_q64(64'd993133, 64'd1000000);
  localparam word_t C_L    = frac_q64(64'd7859453, 64'd10000000);
  localparam word_t RATE_G = frac_q64(64'd99997361, 64'd36525000000);
  localparam word_t RATE_L = frac_q64(64'd61912, 64'd473364000000);
  localparam word_t RATE_E = mul_hi(frac_q64(64'd2269, 64'd365250000000), INV_TWO_PI_Q64);
  localparam word_t EPS0   = mul_hi(frac_q64(64'd408982, 64'd1000000), INV_TWO_PI_Q64);
  localparam word_t K1     = frac_q64(64'd6893, 64'd1296000);
  localparam word_t K2     = frac_q64(64'd72, 64'd1296000);
  localparam word_t TT0_G  = time_term(J2000_DATE, RATE_G);
  localparam word_t TT0_L  = time_term(J2000_DATE, RATE_L);
  localparam word_t TT0_E  = time_term(J2000_DATE, RATE_E);

endpackage

>>> hdl/sdv_sin.sv
module sdv_sin
  import sdv_pkg::*;
(
  input  logic  clk,
  input  word_t ang,
  output word_t mag,
  output logic  neg
);

  // Stages 0-1: quadrant and angle within quadrant in radians
  pp_t          pp0_r;
  logic [1:0]   quad0_r;
  word_t        th_r;
  logic [1:0]   quad1_r;
  logic [127:0] th_w;

  always_comb begin
    th_w = pp_sum(pp0_r);
  end

  always_ff @(posedge clk) begin
    pp0_r   <= mul_pp({ang[61:0], 2'b00}, HALF_PI_Q62);
    quad0_r <= ang[63:62];
    th_r    <= th_w[127:64];
    quad1_r <= quad0_r;
  end

  // Stages 2-3: square and first series term
  pp_t          pp1_r;
  word_t        th1_r;
  logic [1:0]   quad2_r;
  logic [127:0] t2_w;
  word_t        t2_r   [9];
  word_t        term_r [9];
  word_t        sum_r  [9];
  logic [1:0]   quad_r [9];

  always_comb begin
    t2_w = pp_sum(pp1_r);
  end

  always_ff @(posedge clk) begin
    pp1_r     <= mul_pp(th_r, th_r);
    th1_r     <= th_r;
    quad2_r   <= quad1_r;
    t2_r[0]   <= t2_w[125:62];
    term_r[0] <= quad2_r[0] ? ONE_Q62 : th1_r;
    sum_r[0]  <= quad2_r[0] ? ONE_Q62 : th1_r;
    quad_r[0] <= quad2_r;
  end

  // Series steps, four register stages each: product, sum, reciprocal
  // product, quotient
  for (genvar k = 0; k < 8; k++) begin : g_step
    localparam int D_COS = (2 * k + 1) * (2 * k + 2);
    localparam int D_SIN = (2 * k + 2) * (2 * k + 3);
    localparam int L_COS = $clog2(D_COS);
    localparam int L_SIN = $clog2(D_SIN);
    localparam logic [64:0] M_COS = recip_m(D_COS, L_COS);
    localparam logic [64:0] M_SIN = recip_m(D_SIN, L_SIN);

    pp_t          pp_a_r;
    word_t        t2_a_r, sum_a_r;
    logic [1:0]   quad_a_r;
    word_t        prod_b_r, t2_b_r, sum_b_r;
    logic [1:0]   quad_b_r;
    pp_t          pp_c_r;
    word_t        prod_c_r, t2_c_r, sum_c_r;
    logic [1:0]   quad_c_r;
    logic [127:0] prod_w;
    logic [128:0] quo_w, q_cos, q_sin;
    word_t        term;

    // Multiplier is 2^64 plus its low word, so the product itself is added
    always_comb begin
      prod_w = pp_sum(pp_a_r);
      quo_w  = {1'b0, pp_sum(pp_c_r)} + {1'b0, prod_c_r, 64'd0};
      q_cos  = quo_w >> (64 + L_COS);
      q_sin  = quo_w >> (64 + L_SIN);
      term   = quad_c_r[0] ? q_cos[63:0] : q_sin[63:0];
    end

    always_ff @(posedge clk) begin
      pp_a_r      <= mul_pp(term_r[k], t2_r[k]);
      t2_a_r      <= t2_r[k];
      sum_a_r     <= sum_r[k];
      quad_a_r    <= quad_r[k];
      prod_b_r    <= prod_w[125:62];
      t2_b_r      <= t2_a_r;
      sum_b_r     <= sum_a_r;
      quad_b_r    <= quad_a_r;
      pp_c_r      <= mul_pp(prod_b_r, quad_b_r[0] ? M_COS[63:0] : M_SIN[63:0]);
      prod_c_r    <= prod_b_r;
      t2_c_r      <= t2_b_r;
      sum_c_r     <= sum_b_r;
      quad_c_r    <= quad_b_r;
      t2_r[k+1]   <= t2_c_r;
      term_r[k+1] <= term;
      sum_r[k+1]  <= (k % 2 == 0) ? sum_c_r - term : sum_c_r + term;
      quad_r[k+1] <= quad_c_r;
    end
  end

  // Clamp to [0, 1]
  word_t mag_r;
  logic  neg_r;

  always_ff @(posedge clk) begin
    if (sum_r[8][63]) begin
      mag_r <= '0;
    end else if (sum_r[8] > ONE_Q62) begin
      mag_r <= ONE_Q62;
    end else begin
      mag_r <= sum_r[8];
    end
    neg_r <= quad_r[8][1];
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

>>> hdl/sun_direction_vector.sv
// Channel   Ports                                   Handshake
// input     start, busy, in_julian_date             taken when start && !busy
// result    out_valid, out_sun_x/_y/_z              one cycle, strobe out_valid
//
// Items pass in order from start to out_valid; a new item
// may enter every cycle. The pipeline is made of two chained ranks of 37-stage
// sine units and ten surrounding register stages (input, two-stage 64-bit
// products, angles, longitude, rounding). busy is always low.
// rst_n (synchronous) clears only the valid bits; data registers run free.
// The receiver cannot stall, so the pipeline never holds.
module sun_direction_vector
  import sdv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [DATE_W-1:0]        in_julian_date,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_sun_x,
  output logic signed [OUT_W-1:0]  out_sun_y,
  output logic signed [OUT_W-1:0]  out_sun_z
);

  logic [PIPE_LAT-1:0] v_r;
  logic [PIPE_LAT-1:0] v_nxt;

  assign busy = 1'b0;

  // Valid bits travel with the data
  assign v_nxt = {v_r[PIPE_LAT-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Input register
  word_t jd_r;
  always_ff @(posedge clk) begin
    jd_r <= {{(64 - DATE_W){1'b0}}, in_julian_date};
  end

  // Time-term products: partial products, then sums
  pp_t          ppg_r, ppl_r, ppe_r;
  word_t        tg_r, tl_r, te_r;
  logic [127:0] ttg_w, ttl_w, tte_w;
  always_comb begin
    ttg_w = pp_sum(ppg_r);
    ttl_w = pp_sum(ppl_r);
    tte_w = pp_sum(ppe_r);
  end

  always_ff @(posedge clk) begin
    ppg_r <= mul_pp(jd_r, RATE_G);
    ppl_r <= mul_pp(jd_r, RATE_L);
    ppe_r <= mul_pp(jd_r, RATE_E);
    tg_r  <= ttg_w[TIME_FRAC_BITS +: 64];
    tl_r  <= ttl_w[TIME_FRAC_BITS +: 64];
    te_r  <= tte_w[TIME_FRAC_BITS +: 64];
  end

  // Mean anomaly, longitude base, obliquity
  word_t g_r, lam0_r, eps_r;
  word_t g_c;
  always_comb begin
    g_c = (tg_r + (C_G - TT0_G)) & ANGLE_MASK;
  end

  always_ff @(posedge clk) begin
    g_r    <= g_c;
    lam0_r <= g_c + tl_r + (C_L - TT0_L);
    eps_r  <= ((EPS0 + TT0_E) - te_r) & ANGLE_MASK;
  end

  // Equation of center sines
  word_t s1, s2;
  logic  n1, n2;

  sdv_sin u_sin_g1 (.clk(clk), .ang(g_r),              .mag(s1), .neg(n1));
  sdv_sin u_sin_g2 (.clk(clk), .ang({g_r[62:0], 1'b0}), .mag(s2), .neg(n2));

  // Delay longitude base and obliquity alongside the sine units
  word_t lam_dly_r [SIN_LAT+1];
  word_t eps_dly_r [SIN_LAT+1];
  always_ff @(posedge clk) begin
    lam_dly_r[0] <= lam0_r;
    eps_dly_r[0] <= eps_r;
    for (int i = 1; i < SIN_LAT + 1; i++) begin
      lam_dly_r[i] <= lam_dly_r[i-1];
      eps_dly_r[i] <= eps_dly_r[i-1];
    end
  end

  // Center terms, two stages
  pp_t          ppd1_r, ppd2_r;
  logic         n1_a_r, n2_a_r;
  logic [127:0] d1_w, d2_w;
  word_t        d1_r, d2_r, lamb_r, epsb_r;
  logic         n1_r, n2_r;
  always_comb begin
    d1_w = pp_sum(ppd1_r);
    d2_w = pp_sum(ppd2_r);
  end

  always_ff @(posedge clk) begin
    ppd1_r <= mul_pp(s1, K1);
    ppd2_r <= mul_pp(s2, K2);
    n1_a_r <= n1;
    n2_a_r <= n2;
    d1_r   <= {d1_w[125:64], 2'b00};
    d2_r   <= {d2_w[125:64], 2'b00};
    n1_r   <= n1_a_r;
    n2_r   <= n2_a_r;
    lamb_r <= lam_dly_r[SIN_LAT];
    epsb_r <= eps_dly_r[SIN_LAT];
  end

  // Ecliptic longitude
  word_t lam_r, epsc_r;
  word_t lam_a, lam_b;
  always_comb begin
    lam_a = n1_r ? lamb_r - d1_r : lamb_r + d1_r;
    lam_b = n2_r ? lam_a - d2_r : lam_a + d2_r;
  end

  always_ff @(posedge clk) begin
    lam_r  <= lam_b & ANGLE_MASK;
    epsc_r <= epsb_r;
  end

  // Sine and cosine of longitude and obliquity
  word_t sl, cl, se, ce;
  logic  nsl, ncl, nse, nce;

  sdv_sin u_sin_sl (.clk(clk), .ang(lam_r),                 .mag(sl), .neg(nsl));
  sdv_sin u_sin_cl (.clk(clk), .ang(lam_r + QUARTER_TURN),  .mag(cl), .neg(ncl));
  sdv_sin u_sin_se (.clk(clk), .ang(epsc_r),                .mag(se), .neg(nse));
  sdv_sin u_sin_ce (.clk(clk), .ang(epsc_r + QUARTER_TURN), .mag(ce), .neg(nce));

  // Products, two stages
  pp_t          ppy_r, ppz_r;
  word_t        cl_a_r;
  logic         sx_a_r, sy_a_r, sz_a_r;
  logic [127:0] py_w, pz_w;
  word_t        px_r, py_r, pz_r;
  logic         sx_r, sy_r, sz_r;
  always_comb begin
    py_w = pp_sum(ppy_r);
    pz_w = pp_sum(ppz_r);
  end

  always_ff @(posedge clk) begin
    ppy_r  <= mul_pp(ce, sl);
    ppz_r  <= mul_pp(se, sl);
    cl_a_r <= cl;
    sx_a_r <= ncl;
    sy_a_r <= nce ^ nsl;
    sz_a_r <= nse ^ nsl;
    px_r   <= cl_a_r;
    py_r   <= py_w[125:62];
    pz_r   <= pz_w[125:62];
    sx_r   <= sx_a_r;
    sy_r   <= sy_a_r;
    sz_r   <= sz_a_r;
  end

  // Rounding and output registers
  logic [OUT_W-1:0] x_r, y_r, z_r;
  always_ff @(posedge clk) begin
    x_r <= encode_out(px_r, sx_r);
    y_r <= encode_out(py_r, sy_r);
    z_r <= encode_out(pz_r, sz_r);
  end

  assign out_valid = v_r[PIPE_LAT-1];
  assign out_sun_x = x_r;
  assign out_sun_y = y_r;
  assign out_sun_z = z_r;

`ifndef SYNTHESIS
  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1) <<< OUT_FRAC_BITS;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("item did not reach the output after the pipeline latency");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sun_x <= ONE_OUT && out_sun_x >= -ONE_OUT))
    else $error("x component out of unit range");

  a_yz_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sun_y <= ONE_OUT && out_sun_y >= -ONE_OUT &&
                   out_sun_z <= ONE_OUT && out_sun_z >= -ONE_OUT))
    else $error("y or z component out of unit range");
`endif

endmodule
